/* sv/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/dccd_pkg.sv */
// Types and constants for the disk channel command decoder.
// No dependencies; used by disk_channel_command_decoder.
package dccd_pkg;

   localparam int unsigned TRACK_W  = 11;
   localparam int unsigned SBYTES_W = 16;
   localparam int unsigned ADDR_W   = 24;
   localparam int unsigned OFFSET_W = 30;

   localparam logic OPN_ATTENTION = 1'b0;
   localparam logic OPN_RESET     = 1'b1;

   localparam logic [7:0] OP_READ        = 8'd0;
   localparam logic [7:0] OP_WR_SECTOR   = 8'd1;
   localparam logic [7:0] OP_READ_HEADER = 8'd2;
   localparam logic [7:0] OP_FORMAT      = 8'd3;
   localparam logic [7:0] OP_SPECIFY     = 8'd4;
   localparam logic [7:0] OP_GET_STATUS  = 8'd5;
   localparam logic [7:0] OP_NOP         = 8'd6;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_WRITE  = 2'd2;
   localparam logic [1:0] KIND_FORMAT = 2'd3;

   localparam logic [7:0] ST_GOOD       = 8'hFF;
   localparam logic [7:0] ST_ILLEGAL    = 8'hA0;
   localparam logic [7:0] ST_SENSE_BASE = 8'hE0;
   localparam logic [7:0] ST_SENSE_RDY  = 8'h02;
   localparam logic [7:0] ST_SENSE_TRK  = 8'h01;

   localparam logic [2:0]          HEAD_INVERT = 3'h7;
   localparam logic [SBYTES_W-1:0] BOOT_BYTES  = 16'd1024;

   typedef struct packed {
      logic        operation;
      logic [7:0]  opcode;
      logic [1:0]  drive_number;
      logic        seek_inward;
      logic [15:0] step_count;
      logic [2:0]  head_bits;
      logic [7:0]  arg_zero;
      logic [7:0]  arg_one;
      logic [7:0]  arg_two;
      logic [7:0]  arg_three;
      logic [23:0] link_address;
      logic [23:0] boot_pointer;
   } req_type;

   typedef struct packed {
      logic [7:0]  status_byte;
      logic [23:0] command_address;
      logic [1:0]  transfer_kind;
      logic [29:0] transfer_offset;
      logic [15:0] transfer_length;
      logic [7:0]  sector_count;
      logic [7:0]  fill_value;
      logic        track_mismatch;
   } rsp_type;

endpackage

/* sv/disk_channel_command_decoder.sv */
// An accepted command beat is registered in s1 and then in the rsp register.
// Throughput: one beat per cycle; both registers advance every cycle unless rsp stalls.
// A controller reset beat gives no rsp beat and only arms the channel reload.
// Synchronous active-high reset: drive tracks and sector sizes to zero,
// channel address to zero, reload armed, both stages empty.
// Depends on dccd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module disk_channel_command_decoder #(
   parameter int unsigned DRIVE_COUNT       = 4,
   parameter int unsigned SECTORS_PER_TRACK = 17,
   parameter int unsigned HEAD_COUNT        = 8,
   parameter int unsigned SECTOR_STRIDE     = 2048,
   parameter int unsigned TRACK_COUNT       = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dccd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dccd_pkg::rsp_type rsp_payload
);

   localparam logic [dccd_pkg::TRACK_W-1:0] TRACK_TOP = dccd_pkg::TRACK_W'(TRACK_COUNT - 1);

   logic              s1_valid_ff;
   dccd_pkg::req_type s1_payload_ff;
   logic              s1_adv;

   logic              rsp_valid_ff, rsp_valid_in;
   dccd_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic [dccd_pkg::TRACK_W-1:0]  track_position_ff [DRIVE_COUNT];
   logic [dccd_pkg::TRACK_W-1:0]  track_position_in [DRIVE_COUNT];
   logic [dccd_pkg::SBYTES_W-1:0] sector_bytes_ff [DRIVE_COUNT];
   logic [dccd_pkg::SBYTES_W-1:0] sector_bytes_in [DRIVE_COUNT];
   logic [dccd_pkg::ADDR_W-1:0]   channel_address_ff, channel_address_in;
   logic                          reload_pending_ff, reload_pending_in;

   logic                          drv_present;
   logic [dccd_pkg::TRACK_W-1:0]  trk_cur, trk_new;
   logic [dccd_pkg::SBYTES_W-1:0] secsize;
   logic [16:0]                   trk_sum;
   logic [7:0]                    off_head, off_sector;
   logic [31:0]                   lin_sector, off_full;
   logic                          is_cmd;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign is_cmd    = (s1_payload_ff.operation == dccd_pkg::OPN_ATTENTION);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_payload_ff <= req_payload;
      end
   end

   always_comb begin
      drv_present = 1'b0;
      trk_cur     = '0;
      secsize     = '0;
      for (int k = 0; k < DRIVE_COUNT; k++) begin
         if (s1_payload_ff.drive_number == 2'(k)) begin
            drv_present = 1'b1;
            trk_cur     = track_position_ff[k];
            secsize     = sector_bytes_ff[k];
         end
      end
      if (s1_payload_ff.opcode == dccd_pkg::OP_READ && s1_payload_ff.drive_number == 2'd0
          && s1_payload_ff.arg_three == 8'd0 && s1_payload_ff.arg_two == 8'd0
          && trk_cur == '0) begin
         secsize = dccd_pkg::BOOT_BYTES;
      end

      trk_sum = 17'(trk_cur) + 17'(s1_payload_ff.step_count);
      if (s1_payload_ff.seek_inward) begin
         if (16'(trk_cur) >= s1_payload_ff.step_count) begin
            trk_new = trk_cur - s1_payload_ff.step_count[dccd_pkg::TRACK_W-1:0];
         end else begin
            trk_new = '0;
         end
      end else if (trk_sum > 17'(TRACK_TOP)) begin
         trk_new = TRACK_TOP;
      end else begin
         trk_new = trk_sum[dccd_pkg::TRACK_W-1:0];
      end

      if (s1_payload_ff.opcode == dccd_pkg::OP_FORMAT) begin
         off_head   = {5'd0, s1_payload_ff.head_bits ^ dccd_pkg::HEAD_INVERT};
         off_sector = 8'd0;
      end else begin
         off_head   = s1_payload_ff.arg_two;
         off_sector = s1_payload_ff.arg_three;
      end
      lin_sector = (32'(trk_new) * 32'(HEAD_COUNT) + 32'(off_head)) * 32'(SECTORS_PER_TRACK)
                   + 32'(off_sector);
      off_full   = lin_sector * 32'(SECTOR_STRIDE);

      track_position_in  = track_position_ff;
      sector_bytes_in    = sector_bytes_ff;
      channel_address_in = channel_address_ff;
      reload_pending_in  = reload_pending_ff;

      rsp_payload_in                 = '0;
      rsp_payload_in.status_byte     = dccd_pkg::ST_ILLEGAL;
      rsp_payload_in.command_address = reload_pending_ff ? s1_payload_ff.boot_pointer
                                                         : channel_address_ff;

      if (!is_cmd) begin
         reload_pending_in = 1'b1;
      end else begin
         reload_pending_in  = 1'b0;
         channel_address_in = s1_payload_ff.link_address;
         if (drv_present) begin
            for (int k = 0; k < DRIVE_COUNT; k++) begin
               if (s1_payload_ff.drive_number == 2'(k)) begin
                  track_position_in[k] = trk_new;
               end
            end
            case (s1_payload_ff.opcode)
               dccd_pkg::OP_READ, dccd_pkg::OP_WR_SECTOR: begin
                  rsp_payload_in.transfer_kind   = (s1_payload_ff.opcode == dccd_pkg::OP_READ)
                                                   ? dccd_pkg::KIND_READ : dccd_pkg::KIND_WRITE;
                  rsp_payload_in.transfer_offset = off_full[dccd_pkg::OFFSET_W-1:0];
                  rsp_payload_in.transfer_length = secsize;
                  rsp_payload_in.track_mismatch  =
                     (16'(trk_new) != {s1_payload_ff.arg_one, s1_payload_ff.arg_zero});
                  rsp_payload_in.status_byte     = dccd_pkg::ST_GOOD;
               end
               dccd_pkg::OP_READ_HEADER, dccd_pkg::OP_NOP: begin
                  rsp_payload_in.status_byte = dccd_pkg::ST_GOOD;
               end
               dccd_pkg::OP_FORMAT: begin
                  rsp_payload_in.transfer_kind   = dccd_pkg::KIND_FORMAT;
                  rsp_payload_in.transfer_offset = off_full[dccd_pkg::OFFSET_W-1:0];
                  rsp_payload_in.transfer_length =
                     {{1'b0, ~s1_payload_ff.arg_two} + 9'd1, 7'd0};
                  rsp_payload_in.sector_count    = ~s1_payload_ff.arg_one;
                  rsp_payload_in.fill_value      = s1_payload_ff.arg_three;
                  rsp_payload_in.status_byte     = dccd_pkg::ST_GOOD;
               end
               dccd_pkg::OP_SPECIFY: begin
                  for (int k = 0; k < DRIVE_COUNT; k++) begin
                     if (s1_payload_ff.drive_number == 2'(k)) begin
                        sector_bytes_in[k] = {{1'b0, s1_payload_ff.arg_three} + 9'd1, 7'd0};
                     end
                  end
                  rsp_payload_in.status_byte = dccd_pkg::ST_GOOD;
               end
               dccd_pkg::OP_GET_STATUS: begin
                  rsp_payload_in.status_byte = dccd_pkg::ST_SENSE_BASE | dccd_pkg::ST_SENSE_RDY
                     | ((trk_new != '0) ? dccd_pkg::ST_SENSE_TRK : 8'h00);
               end
               default: begin
                  rsp_payload_in.status_byte = dccd_pkg::ST_ILLEGAL;
               end
            endcase
         end
      end

      if (s1_adv) begin
         rsp_valid_in = is_cmd;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DRIVE_COUNT; k++) begin
            track_position_ff[k] <= '0;
            sector_bytes_ff[k]   <= '0;
         end
         channel_address_ff <= '0;
         reload_pending_ff  <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (s1_adv) begin
            track_position_ff  <= track_position_in;
            sector_bytes_ff    <= sector_bytes_in;
            channel_address_ff <= channel_address_in;
            reload_pending_ff  <= reload_pending_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_SAME(a_stall_blocks_req, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   `ASSERT_NEXT(a_reset_beat_silent, clock, reset,
      s1_adv && !is_cmd, !rsp_valid_ff && reload_pending_ff)
   `ASSERT_NEXT(a_cmd_clears_reload, clock, reset,
      s1_adv && is_cmd, rsp_valid_ff && !reload_pending_ff)
   `ASSERT_SAME(a_no_transfer_zero, clock, reset,
      rsp_valid_ff && rsp_payload_ff.transfer_kind == dccd_pkg::KIND_NONE,
      rsp_payload_ff.transfer_offset == '0 && rsp_payload_ff.transfer_length == '0)

endmodule

/* tb/sv/dccd_scoreboard_pkg.sv */
// Scoreboard for the disk channel command decoder testbench: tracks drive and
// channel state from accepted command beats and checks every result beat.
// Depends on dccd_pkg.
package dccd_scoreboard_pkg;
   import dccd_pkg::*;

   localparam int unsigned DRIVE_COUNT       = 4;
   localparam int unsigned SECTORS_PER_TRACK = 17;
   localparam int unsigned HEAD_COUNT        = 8;
   localparam int unsigned SECTOR_STRIDE     = 2048;
   localparam int unsigned TRACK_COUNT       = 2048;
   localparam int unsigned SIZE_UNIT         = 128;
   localparam int          MAX_REPORTS       = 40;

   class dccd_scoreboard;
      logic [TRACK_W-1:0]  track_pos [DRIVE_COUNT];
      logic [SBYTES_W-1:0] sector_size [DRIVE_COUNT];
      logic [ADDR_W-1:0]   chan_addr;
      bit                  reload_armed;
      rsp_type             expected_q [$];
      int                  errors;
      int                  checked;
      int                  commands;
      int                  reset_events;
      int                  boot_reads;
      int                  sense_beats;
      int                  kind_count [4];

      function new();
         foreach (track_pos[k]) begin
            track_pos[k]   = '0;
            sector_size[k] = '0;
         end
         foreach (kind_count[k]) kind_count[k] = 0;
         chan_addr    = '0;
         reload_armed = 1'b1;
         errors       = 0;
         checked      = 0;
         commands     = 0;
         reset_events = 0;
         boot_reads   = 0;
         sense_beats  = 0;
      endfunction

      function logic [TRACK_W-1:0] step_track(input logic [TRACK_W-1:0] start,
                                              input logic down,
                                              input logic [15:0] steps);
         int unsigned t;
         if (down) begin
            t = (start >= steps) ? start - steps : 0;
         end else begin
            t = start + steps;
            if (t > TRACK_COUNT - 1) t = TRACK_COUNT - 1;
         end
         return t[TRACK_W-1:0];
      endfunction

      function logic [TRACK_W-1:0] projected_track(input logic [1:0] drive,
                                                   input logic down,
                                                   input logic [15:0] steps);
         return step_track(track_pos[drive], down, steps);
      endfunction

      function logic [OFFSET_W-1:0] image_offset(input logic [TRACK_W-1:0] trk,
                                                 input logic [7:0] head,
                                                 input logic [7:0] sector);
         bit [63:0] v;
         v = ((64'(trk) * HEAD_COUNT + 64'(head)) * SECTORS_PER_TRACK + 64'(sector))
             * SECTOR_STRIDE;
         return v[OFFSET_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(input req_type r);
         rsp_type             e;
         logic [TRACK_W-1:0]  prior;
         logic [TRACK_W-1:0]  stepped;
         logic [SBYTES_W-1:0] len;
         int unsigned         bytes;
         if (r.operation == OPN_RESET) begin
            reload_armed = 1'b1;
            reset_events++;
            return;
         end
         commands++;
         if (reload_armed) begin
            chan_addr    = r.boot_pointer;
            reload_armed = 1'b0;
         end
         e                 = '0;
         e.status_byte     = ST_ILLEGAL;
         e.command_address = chan_addr;
         if (r.drive_number < DRIVE_COUNT) begin
            prior   = track_pos[r.drive_number];
            stepped = step_track(prior, r.seek_inward, r.step_count);
            len     = sector_size[r.drive_number];
            if (r.opcode == OP_READ && r.drive_number == 2'd0 && r.arg_two == 8'd0 &&
                r.arg_three == 8'd0 && prior == '0) begin
               len = BOOT_BYTES;
               boot_reads++;
            end
            track_pos[r.drive_number] = stepped;
            case (r.opcode)
               OP_READ, OP_WR_SECTOR: begin
                  e.transfer_kind   = (r.opcode == OP_READ) ? KIND_READ : KIND_WRITE;
                  e.transfer_offset = image_offset(stepped, r.arg_two, r.arg_three);
                  e.transfer_length = len;
                  e.track_mismatch  = (16'(stepped) != {r.arg_one, r.arg_zero});
                  e.status_byte     = ST_GOOD;
               end
               OP_READ_HEADER, OP_NOP: begin
                  e.status_byte = ST_GOOD;
               end
               OP_FORMAT: begin
                  bytes             = SIZE_UNIT * ((r.arg_two ^ 8'hFF) + 1);
                  e.transfer_kind   = KIND_FORMAT;
                  e.transfer_length = bytes[SBYTES_W-1:0];
                  e.sector_count    = r.arg_one ^ 8'hFF;
                  e.fill_value      = r.arg_three;
                  e.transfer_offset = image_offset(stepped, 8'(r.head_bits ^ HEAD_INVERT),
                                                   8'd0);
                  e.status_byte     = ST_GOOD;
               end
               OP_SPECIFY: begin
                  bytes                        = SIZE_UNIT * (r.arg_three + 1);
                  sector_size[r.drive_number] = bytes[SBYTES_W-1:0];
                  e.status_byte                = ST_GOOD;
               end
               OP_GET_STATUS: begin
                  e.status_byte = ST_SENSE_BASE | ST_SENSE_RDY |
                                  ((stepped != '0) ? ST_SENSE_TRK : 8'h00);
                  sense_beats++;
               end
               default: begin
                  e.status_byte = ST_ILLEGAL;
               end
            endcase
         end
         kind_count[e.transfer_kind]++;
         expected_q.push_back(e);
         chan_addr = r.link_address;
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch %0d at result %0d, %s: got 0x%0h, want 0x%0h",
                     errors, checked, what, got, want);
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("beat with nothing outstanding", 32'd0, 32'd0);
            return;
         end
         want = expected_q.pop_front();
         if (got.status_byte !== want.status_byte)
            report_mismatch("status_byte", got.status_byte, want.status_byte);
         if (got.command_address !== want.command_address)
            report_mismatch("command_address", got.command_address, want.command_address);
         if (got.transfer_kind !== want.transfer_kind)
            report_mismatch("transfer_kind", got.transfer_kind, want.transfer_kind);
         if (got.transfer_offset !== want.transfer_offset)
            report_mismatch("transfer_offset", got.transfer_offset, want.transfer_offset);
         if (got.transfer_length !== want.transfer_length)
            report_mismatch("transfer_length", got.transfer_length, want.transfer_length);
         if (got.sector_count !== want.sector_count)
            report_mismatch("sector_count", got.sector_count, want.sector_count);
         if (got.fill_value !== want.fill_value)
            report_mismatch("fill_value", got.fill_value, want.fill_value);
         if (got.track_mismatch !== want.track_mismatch)
            report_mismatch("track_mismatch", got.track_mismatch, want.track_mismatch);
         checked++;
      endtask
   endclass

endpackage

/* tb/sv/tb_disk_channel_command_decoder.sv */
// Top-level testbench for disk_channel_command_decoder: directed and random
// command beats with random idling on both channels, checked by the scoreboard.
// Depends on dccd_pkg, dccd_scoreboard_pkg and the decoder RTL.
module tb_disk_channel_command_decoder;
   import dccd_pkg::*;
   import dccd_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS     = 700;
   localparam int HOLD_AFTER_BEATS = 150;
   localparam int HOLD_CYCLES      = 60;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_TIME    = 2000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   dccd_scoreboard sb = new();
   int             offered;
   int             rsp_beats;
   int             hold_seen;

   disk_channel_command_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic req_type make_cmd(input logic [7:0] opcode, input logic [1:0] drive,
                                        input logic down, input logic [15:0] steps,
                                        input logic [2:0] heads, input logic [7:0] a0,
                                        input logic [7:0] a1, input logic [7:0] a2,
                                        input logic [7:0] a3);
      req_type r;
      r.operation    = OPN_ATTENTION;
      r.opcode       = opcode;
      r.drive_number = drive;
      r.seek_inward  = down;
      r.step_count   = steps;
      r.head_bits    = heads;
      r.arg_zero     = a0;
      r.arg_one      = a1;
      r.arg_two      = a2;
      r.arg_three    = a3;
      r.link_address = 24'($urandom);
      r.boot_pointer = 24'($urandom);
      return r;
   endfunction

   function automatic req_type random_command();
      req_type     r;
      int          pick;
      logic [15:0] cyl;
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.opcode = OP_READ;
      else if (pick < 50) r.opcode = OP_WR_SECTOR;
      else if (pick < 90) r.opcode = 8'($urandom_range(OP_READ_HEADER, OP_NOP));
      else                r.opcode = 8'($urandom_range(OP_NOP + 1, 8'hFF));
      r.operation    = OPN_ATTENTION;
      r.drive_number = 2'($urandom_range(0, 3));
      r.seek_inward  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 5)      r.step_count = 16'($urandom_range(0, 3));
      else if (pick < 7) r.step_count = 16'($urandom_range(0, 40));
      else if (pick < 8) r.step_count = 16'($urandom_range(2040, 2050));
      else               r.step_count = 16'($urandom);
      r.head_bits = 3'($urandom);
      r.arg_two   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      r.arg_three = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      if ((r.opcode == OP_READ || r.opcode == OP_WR_SECTOR) && $urandom_range(0, 2) != 0)
         cyl = 16'(sb.projected_track(r.drive_number, r.seek_inward, r.step_count));
      else
         cyl = 16'($urandom);
      {r.arg_one, r.arg_zero} = cyl;
      r.link_address = 24'($urandom);
      r.boot_pointer = 24'($urandom);
      return r;
   endfunction

   function automatic req_type reset_event();
      req_type r;
      r           = random_command();
      r.operation = OPN_RESET;
      return r;
   endfunction

   task automatic offer_beat(input req_type item);
      int gap;
      gap = (offered % 80 < 20) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(item);
      offered++;
   endtask

   initial begin : rsp_side
      int  stall;
      bit  hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = (rsp_beats % 64 < 16) ? 0 : $urandom_range(0, 4);
         if (!hold_done && rsp_beats == HOLD_AFTER_BEATS) begin
            hold_done = 1'b1;
            stall     = HOLD_CYCLES;
            hold_seen = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_response(rsp_payload);
         rsp_beats++;
      end
   end

   initial begin : watchdog
      #(WATCHDOG_TIME);
      $display("FAILURE");
      $finish;
   end

   initial begin : req_side
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      offer_beat(make_cmd(OP_READ,        2'd0, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_READ,        2'd0, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h01, 8'h03));
      offer_beat(make_cmd(OP_SPECIFY,     2'd0, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'hFF));
      offer_beat(make_cmd(OP_SPECIFY,     2'd1, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_WR_SECTOR,   2'd1, 1'b0, 16'hFFFF, 3'h0, 8'hFF, 8'h07, 8'h00, 8'h01));
      offer_beat(make_cmd(OP_READ,        2'd1, 1'b1, 16'hFFFF, 3'h0, 8'hFF, 8'hFF, 8'h02, 8'h00));
      offer_beat(make_cmd(OP_FORMAT,      2'd2, 1'b0, 16'd2047, 3'h0, 8'h00, 8'h00, 8'h00, 8'hFF));
      offer_beat(make_cmd(OP_FORMAT,      2'd3, 1'b0, 16'd1,    3'h7, 8'h00, 8'hFF, 8'hFF, 8'h00));
      offer_beat(make_cmd(OP_READ_HEADER, 2'd2, 1'b1, 16'd1,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_GET_STATUS,  2'd2, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_GET_STATUS,  2'd0, 1'b1, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_NOP,         2'd3, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_NOP + 8'd1,  2'd1, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(8'hFF,          2'd2, 1'b0, 16'd3,    3'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      offer_beat(reset_event());
      offer_beat(make_cmd(OP_READ,        2'd0, 1'b0, 16'hFFFF, 3'h5, 8'hFF, 8'h07, 8'hFF, 8'hFF));
      offer_beat(reset_event());
      offer_beat(reset_event());
      offer_beat(make_cmd(OP_READ,        2'd0, 1'b1, 16'hFFFF, 3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_READ,        2'd0, 1'b0, 16'd5,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_READ,        2'd1, 1'b0, 16'd0,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_WR_SECTOR,   2'd0, 1'b1, 16'd5,    3'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      offer_beat(make_cmd(OP_WR_SECTOR,   2'd3, 1'b1, 16'd0,    3'h2, 8'h80, 8'h80, 8'h80, 8'h80));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 19) == 0) offer_beat(reset_event());
         else                            offer_beat(random_command());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $write("Ran %0d commands and %0d controller resets: %0d none, %0d reads, ",
             sb.commands, sb.reset_events, sb.kind_count[KIND_NONE],
             sb.kind_count[KIND_READ]);
      $display("%0d writes, %0d formats, %0d boot reads, %0d senses.",
               sb.kind_count[KIND_WRITE], sb.kind_count[KIND_FORMAT], sb.boot_reads,
               sb.sense_beats);
      $display("Checked %0d result beats with one %0d-cycle receiver hold-off; %0d mismatches.",
               sb.checked, hold_seen, sb.errors);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
